// ===== sv/firewall_rule_matcher_core_assert.svh =====
// Assertion macros for the firewall rule matcher.
// Used by the top level; they expand to nothing when SYNTHESIS is defined.
`ifndef FIREWALL_RULE_MATCHER_CORE_ASSERT_SVH
`define FIREWALL_RULE_MATCHER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent
`define FRM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Consequent must hold in the cycle after the antecedent
`define FRM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FRM_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define FRM_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== sv/frm_pkg.sv =====
// Shared types, codes and verdict mapping for the firewall rule matcher.
// No dependencies; imported by the interfaces and every module.
`default_nettype none
package frm_pkg;

  localparam int ADDR_W     = 32;
  localparam int ACT_W      = 2;
  localparam int IDX_W      = 4;
  localparam int VERDICT_W  = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int COUNT_W    = 5;

  // Item opcodes
  localparam logic OP_WRITE    = 1'b0;
  localparam logic OP_CLASSIFY = 1'b1;

  // Direction codes
  localparam logic DIR_FROM_INSIDE  = 1'b0;
  localparam logic DIR_FROM_OUTSIDE = 1'b1;

  // Rule and default action codes
  localparam logic [ACT_W-1:0] ACT_BLOCK  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_PASS   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_REJECT = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INSIDE_NET     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INSIDE_MASK    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTSIDE_NET    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTSIDE_MASK   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_ACTION = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RULE_COUNT     = 3'd5;

  // Configuration reset values
  localparam logic [ADDR_W-1:0]  RST_INSIDE_NET     = 32'h0A01_0100;
  localparam logic [ADDR_W-1:0]  RST_INSIDE_MASK    = 32'hFFFF_FF00;
  localparam logic [ADDR_W-1:0]  RST_OUTSIDE_NET    = 32'h1401_0100;
  localparam logic [ADDR_W-1:0]  RST_OUTSIDE_MASK   = 32'hFFFF_FF00;
  localparam logic [ACT_W-1:0]   RST_DEFAULT_ACTION = ACT_REJECT;
  localparam logic [COUNT_W-1:0] RST_RULE_COUNT     = 5'd0;

  typedef enum logic [VERDICT_W-1:0] {
    V_IGNORE = 2'd0,
    V_BLOCK  = 2'd1,
    V_PASS   = 2'd2,
    V_REJECT = 2'd3
  } verdict_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_READ,
    S_CMP,
    S_DONE
  } state_t;

  // One stored rule
  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [ADDR_W-1:0] src;
    logic [ADDR_W-1:0] dst;
  } rule_t;

  // Controller to datapath
  typedef struct packed {
    logic load_pkt;
    logic write_rule;
    logic rd_en;
    logic ptr_inc;
    logic set_ignore;
    logic set_default;
    logic set_hit;
    logic load_result;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_range;
    logic n_zero;
    logic match;
    logic last;
    logic out_busy;
  } stat_t;

  // Rule action to verdict; code 3 acts as block
  function automatic verdict_t rule_verdict(input logic [ACT_W-1:0] act);
    verdict_t v;
    unique case (act)
      ACT_PASS:   v = V_PASS;
      ACT_REJECT: v = V_REJECT;
      default:    v = V_BLOCK;
    endcase
    return v;
  endfunction

  // Default action to verdict; code 3 acts as reject
  function automatic verdict_t default_verdict(input logic [ACT_W-1:0] act);
    verdict_t v;
    unique case (act)
      ACT_BLOCK: v = V_BLOCK;
      ACT_PASS:  v = V_PASS;
      default:   v = V_REJECT;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== sv/frm_if.sv =====
// Valid/ready channel interfaces for packet items and verdict results.
// Depends on frm_pkg for field widths.
`default_nettype none
interface frm_in_if
  import frm_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic                  op;
  logic [IDX_W-1:0]      rule_index;
  logic [ACT_W-1:0]      rule_action;
  logic [ADDR_W-1:0]     rule_src;
  logic [ADDR_W-1:0]     rule_dst;
  logic                  direction;
  logic [ADDR_W-1:0]     source_ip;
  logic [ADDR_W-1:0]     dest_ip;

  modport source (
    output valid, op, rule_index, rule_action, rule_src, rule_dst,
           direction, source_ip, dest_ip,
    input  ready
  );
  modport sink (
    input  valid, op, rule_index, rule_action, rule_src, rule_dst,
           direction, source_ip, dest_ip,
    output ready
  );
endinterface

interface frm_out_if
  import frm_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [VERDICT_W-1:0] verdict;
  logic                 hit;
  logic [IDX_W-1:0]     hit_index;

  modport source (
    output valid, verdict, hit, hit_index,
    input  ready
  );
  modport sink (
    input  valid, verdict, hit, hit_index,
    output ready
  );
endinterface
`default_nettype wire

// ===== sv/frm_ctrl.sv =====
// Sequencing state machine for the rule matcher: accepts items, steps the
// rule scan and hands results to the output register. Depends on frm_pkg.
`default_nettype none
module frm_ctrl
  import frm_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  input  wire logic  in_op,
  input  wire stat_t stat,
  output logic       in_ready,
  output cmd_t       cmd,
  output state_t     state
);

  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_op == OP_CLASSIFY) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (!stat.in_range) state_next = S_DONE;
        else if (stat.n_zero)        state_next = S_DONE;
        else                         state_next = S_READ;
      end
      S_READ: state_next = S_CMP;
      S_CMP: begin
        priority if (stat.match) state_next = S_DONE;
        else if (stat.last)      state_next = S_DONE;
        else                     state_next = S_READ;
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_pkt   = (in_op == OP_CLASSIFY);
          cmd.write_rule = (in_op == OP_WRITE);
        end
      end
      S_CHECK: begin
        if (!stat.in_range)   cmd.set_ignore  = 1'b1;
        else if (stat.n_zero) cmd.set_default = 1'b1;
      end
      S_READ: cmd.rd_en = 1'b1;
      S_CMP: begin
        priority if (stat.match) cmd.set_hit     = 1'b1;
        else if (stat.last)      cmd.set_default = 1'b1;
        else                     cmd.ptr_inc     = 1'b1;
      end
      S_DONE: cmd.load_result = !stat.out_busy;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/frm_datapath.sv =====
// Datapath of the rule matcher: configuration registers, rule memory, range
// check, scan pointer, compare and result registers. Depends on frm_pkg.
`default_nettype none
module frm_datapath
  import frm_pkg::*;
#(
  parameter int RULES = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire cmd_t                  cmd,
  output stat_t                      stat,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic [IDX_W-1:0]      rule_index,
  input  wire logic [ACT_W-1:0]      rule_action,
  input  wire logic [ADDR_W-1:0]     rule_src,
  input  wire logic [ADDR_W-1:0]     rule_dst,
  input  wire logic                  direction,
  input  wire logic [ADDR_W-1:0]     source_ip,
  input  wire logic [ADDR_W-1:0]     dest_ip,
  input  wire logic                  out_ready,
  output logic                       out_valid,
  output logic [VERDICT_W-1:0]       out_verdict,
  output logic                       out_hit,
  output logic [IDX_W-1:0]           out_hit_index
);

  localparam int IW = (RULES > 1) ? $clog2(RULES) : 1;
  localparam int CW = $clog2(RULES + 1);

  // Configuration
  logic [ADDR_W-1:0]  inside_net;
  logic [ADDR_W-1:0]  inside_mask;
  logic [ADDR_W-1:0]  outside_net;
  logic [ADDR_W-1:0]  outside_mask;
  logic [ACT_W-1:0]   default_action;
  logic [COUNT_W-1:0] rule_count;

  // Packet under classification
  logic [ADDR_W-1:0] pkt_src;
  logic [ADDR_W-1:0] pkt_dst;
  logic              pkt_dir;

  // Scan
  rule_t          rule_mem [RULES];
  rule_t          rd_data;
  logic [CW-1:0]  ptr;
  logic [CW-1:0]  ptr_plus;
  logic [CW-1:0]  n_active;
  logic           wr_ok;

  // Range check
  logic [ADDR_W-1:0] sel_net;
  logic [ADDR_W-1:0] sel_mask;
  logic [ADDR_W-1:0] range_lo;
  logic [ADDR_W-1:0] range_hi;

  // Staged result
  verdict_t         res_verdict;
  logic             res_hit;
  logic [IDX_W-1:0] res_index;

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      inside_net     <= RST_INSIDE_NET;
      inside_mask    <= RST_INSIDE_MASK;
      outside_net    <= RST_OUTSIDE_NET;
      outside_mask   <= RST_OUTSIDE_MASK;
      default_action <= RST_DEFAULT_ACTION;
      rule_count     <= RST_RULE_COUNT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INSIDE_NET:     inside_net     <= cfg_data;
        CFG_INSIDE_MASK:    inside_mask    <= cfg_data;
        CFG_OUTSIDE_NET:    outside_net    <= cfg_data;
        CFG_OUTSIDE_MASK:   outside_mask   <= cfg_data;
        CFG_DEFAULT_ACTION: default_action <= cfg_data[ACT_W-1:0];
        CFG_RULE_COUNT:     rule_count     <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Latch the packet fields on a classify transfer
  always_ff @(posedge clk) begin
    if (cmd.load_pkt) begin
      pkt_src <= source_ip;
      pkt_dst <= dest_ip;
      pkt_dir <= direction;
    end
  end

  // Rule memory: one write port, one registered read port
  assign wr_ok = (32'(rule_index) < 32'(RULES));

  always_ff @(posedge clk) begin
    if (cmd.write_rule && wr_ok) begin
      rule_mem[IW'(rule_index)] <= '{action: rule_action, src: rule_src, dst: rule_dst};
    end
    if (cmd.rd_en) begin
      rd_data <= rule_mem[ptr[IW-1:0]];
    end
  end

  // Scan pointer: clear on a new packet, advance after each miss but the last
  assign ptr_plus = ptr + CW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
    end else if (cmd.load_pkt) begin
      ptr <= '0;
    end else if (cmd.ptr_inc) begin
      ptr <= ptr_plus;
    end
  end

  // Saturate the active rule count to the table depth
  always_comb begin
    if (32'(rule_count) > 32'(RULES)) begin
      n_active = CW'(RULES);
    end else begin
      n_active = CW'(rule_count);
    end
  end

  // Protected network bounds for the arrival direction
  always_comb begin
    if (pkt_dir == DIR_FROM_OUTSIDE) begin
      sel_net  = inside_net;
      sel_mask = inside_mask;
    end else begin
      sel_net  = outside_net;
      sel_mask = outside_mask;
    end
    range_lo = sel_net & sel_mask;
    range_hi = range_lo | ~sel_mask;
  end

  assign stat.in_range = (pkt_dst >= range_lo) && (pkt_dst <= range_hi);
  assign stat.n_zero   = (n_active == '0);
  assign stat.match    = (rd_data.src == pkt_src) && (rd_data.dst == pkt_dst);
  assign stat.last     = (ptr_plus == n_active);
  assign stat.out_busy = out_valid && !out_ready;

  // Stage the verdict
  always_ff @(posedge clk) begin
    if (cmd.set_ignore) begin
      res_verdict <= V_IGNORE;
      res_hit     <= 1'b0;
      res_index   <= '0;
    end else if (cmd.set_default) begin
      res_verdict <= default_verdict(default_action);
      res_hit     <= 1'b0;
      res_index   <= '0;
    end else if (cmd.set_hit) begin
      res_verdict <= rule_verdict(rd_data.action);
      res_hit     <= 1'b1;
      res_index   <= IDX_W'(ptr);
    end
  end

  // Output register: load a new result, drop it once transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      out_verdict   <= res_verdict;
      out_hit       <= res_hit;
      out_hit_index <= res_index;
    end
  end

endmodule
`default_nettype wire

// ===== sv/firewall_rule_matcher_core.sv =====
// Firewall access-list matcher: first-match classification against a table
// of exact source/destination rules. Depends on frm_pkg, frm_if,
// frm_ctrl, frm_datapath and the assertion macro header.
//
// Usage:
//   pkt_in  carries items: op = write stores one rule at rule_index, op =
//           classify checks a packet (direction, source_ip, dest_ip).
//   res_out carries one verdict per classify item (verdict, hit, hit_index);
//           rule writes give no result.
//   cfg_we / cfg_index / cfg_data write the network, mask, default action
//           and rule count registers; write them only while the block is idle.
// Sequence:
//   A rule write is taken in the idle state. A classify item passes the check
//   state, a read state and a compare state for each rule compared, and the
//   done state, where the result is loaded, before the next item is taken.
//   The scan reads the rule memory through its single registered read port,
//   reading one rule and then comparing it before the next is read.
// Reset: registers take their default values, the rule count is zero and
//   the output is empty; rule slots hold unknown data until written.
// Stall: a result waits in the output register; the next item is taken
//   meanwhile and its result is held until the register frees up.
`default_nettype none
`include "firewall_rule_matcher_core_assert.svh"
module firewall_rule_matcher_core
  import frm_pkg::*;
#(
  parameter int RULES = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  frm_in_if.sink                     pkt_in,
  frm_out_if.source                  res_out
);

  cmd_t   cmd;
  stat_t  stat;
  state_t state;
  logic   in_ready;

  frm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pkt_in.valid),
    .in_op    (pkt_in.op),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd),
    .state    (state)
  );

  frm_datapath #(
    .RULES (RULES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .rule_index    (pkt_in.rule_index),
    .rule_action   (pkt_in.rule_action),
    .rule_src      (pkt_in.rule_src),
    .rule_dst      (pkt_in.rule_dst),
    .direction     (pkt_in.direction),
    .source_ip     (pkt_in.source_ip),
    .dest_ip       (pkt_in.dest_ip),
    .out_ready     (res_out.ready),
    .out_valid     (res_out.valid),
    .out_verdict   (res_out.verdict),
    .out_hit       (res_out.hit),
    .out_hit_index (res_out.hit_index)
  );

  assign pkt_in.ready = in_ready;

  // A classify transfer starts the range check in the next cycle
  `FRM_ASSERT_NEXT(a_classify_starts, clk, rst, pkt_in.valid && pkt_in.ready && pkt_in.op == OP_CLASSIFY, state == S_CHECK && !pkt_in.ready, "classify transfer did not start a check")
  // A loaded result is presented in the next cycle
  `FRM_ASSERT_NEXT(a_result_shown, clk, rst, cmd.load_result, res_out.valid, "loaded result not presented")
  // A rule hit never reports ignore
  `FRM_ASSERT_NOW(a_hit_verdict, clk, rst, res_out.valid && res_out.hit, res_out.verdict != V_IGNORE, "rule hit with ignore verdict")
  // Without a hit the index reads zero
  `FRM_ASSERT_NOW(a_miss_index, clk, rst, res_out.valid && !res_out.hit, res_out.hit_index == '0, "nonzero index without a hit")

endmodule
`default_nettype wire
